// ===== hdl/cbc_pkg.sv =====
`default_nettype none

package cbc_pkg;

    // Default size of the external RAM store in bytes (a power of two).
    localparam int RAM_BYTES_DEFAULT = 32768;

    // Configuration register indexes.
    localparam logic CFG_ROM_BANK_COUNT = 1'b0;
    localparam logic CFG_RAM_SIZE_CODE  = 1'b1;

    // Configuration reset values.
    localparam logic [7:0] ROM_BANK_COUNT_RESET = 8'd128;
    localparam logic [2:0] RAM_SIZE_CODE_RESET  = 3'd0;

    // Installed RAM size codes.
    localparam logic [2:0] RAM_SIZE_NONE = 3'd0;
    localparam logic [2:0] RAM_SIZE_2K   = 3'd1;
    localparam logic [2:0] RAM_SIZE_8K   = 3'd2;
    localparam logic [2:0] RAM_SIZE_32K  = 3'd3;
    localparam logic [2:0] RAM_SIZE_128K = 3'd4;
    localparam logic [2:0] RAM_SIZE_64K  = 3'd5;

    // Access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result outcome codes.
    localparam logic [1:0] OUTCOME_NONE  = 2'd0;
    localparam logic [1:0] OUTCOME_ROM   = 2'd1;
    localparam logic [1:0] OUTCOME_READ  = 2'd2;
    localparam logic [1:0] OUTCOME_WRITE = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BANK_VALUE = 2'd1;
    localparam logic [1:0] ERR_ROM_RANGE  = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [20:0] rom_address;
        logic [7:0]  read_data;
        logic [1:0]  error;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/cbc_ram.sv =====
`default_nettype none

// Single-port synchronous RAM with a registered read.
module cbc_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/cartridge_bank_controller.sv =====
`default_nettype none

// Cartridge bank controller: decodes one CPU bus access per request.
// The req channel carries cmd (read or write), a 16-bit address and a data
// byte; the rsp channel returns one result per request: an outcome code,
// the physical ROM byte address for ROM reads, the RAM byte for RAM reads
// and an error code for bank register writes. Both channels use valid and
// ready. The cfg port writes the ROM bank count and RAM size code with no
// wait; the user must write it only while the block holds no requests,
// as the block itself does not enforce this. Each result is registered in
// the middle stage and then in the result register before rsp_valid rises.
// One request is accepted every cycle while the receiver takes results:
// bank registers update at acceptance and the external RAM is read or
// written in that same cycle through its single port, so no access ever
// waits on another. After reset the block clears all RAM_BYTES bytes of
// the external RAM (32768 at the default), one byte per cycle; req_ready
// stays low meanwhile. A stalled receiver holds the result register; one
// more request can be taken into the middle stage, after which req_ready
// drops until the receiver takes a result. RAM_BYTES must be a power of two.
module cartridge_bank_controller #(
    parameter int RAM_BYTES = cbc_pkg::RAM_BYTES_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire cbc_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output cbc_pkg::rsp_t      rsp,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [7:0]    cfg_data
);

    localparam int AW = $clog2(RAM_BYTES);
    localparam logic [16:0] CapMask = 17'(RAM_BYTES - 1);

    // Address regions, selected by the top three address bits.
    localparam logic [2:0] RGN_ENABLE = 3'd0;
    localparam logic [2:0] RGN_LOW    = 3'd1;
    localparam logic [2:0] RGN_HIGH   = 3'd2;
    localparam logic [2:0] RGN_MODE   = 3'd3;
    localparam logic [2:0] RGN_RAM    = 3'd5;

    // Configuration registers.
    logic [7:0] rom_bank_count_reg;
    logic [2:0] ram_size_code_reg;

    // Bank control state.
    logic       ram_enable_reg, ram_enable_next;
    logic [4:0] bank_low_reg, bank_low_next;
    logic [1:0] bank_high_reg, bank_high_next;
    logic       mode_select_reg, mode_select_next;
    logic [1:0] ram_bank_reg, ram_bank_next;

    // RAM clearing sweep after reset.
    logic          clearing_reg;
    logic [AW-1:0] clear_cnt_reg;

    // Middle stage (waits for the RAM read data) and result register.
    logic          a_valid_reg;
    logic          a_use_ram_reg;
    cbc_pkg::rsp_t a_rsp_reg;
    logic          o_valid_reg;
    cbc_pkg::rsp_t o_rsp_reg, o_rsp_next;

    logic          accept;
    logic          advance;
    cbc_pkg::rsp_t rsp_next;
    logic          use_ram_next;
    logic [16:0]   size_mask;
    logic          ram_present;
    logic [16:0]   ram_index_full;
    logic          ram_active;
    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [4:0]    low_fixed;

    assign advance   = a_valid_reg && (!o_valid_reg || rsp_ready);
    assign req_ready = !clearing_reg && (!a_valid_reg || advance);
    assign accept    = req_valid && req_ready;

    // Installed RAM size as an address mask, capped at the store size.
    always_comb
    begin
        ram_present = 1'b1;
        case (ram_size_code_reg)
            cbc_pkg::RAM_SIZE_2K:   size_mask = 17'h007FF;
            cbc_pkg::RAM_SIZE_8K:   size_mask = 17'h01FFF;
            cbc_pkg::RAM_SIZE_32K:  size_mask = 17'h07FFF;
            cbc_pkg::RAM_SIZE_128K: size_mask = 17'h1FFFF;
            cbc_pkg::RAM_SIZE_64K:  size_mask = 17'h0FFFF;
            default:
            begin
                size_mask   = 17'h00000;
                ram_present = 1'b0;
            end
        endcase
        if (size_mask > CapMask)
        begin
            size_mask = CapMask;
        end
    end

    // Sizes are powers of two, so wrapping the offset is a mask.
    assign ram_index_full = {2'b00, ram_bank_reg, req.address[12:0]} & size_mask;
    assign ram_active     = ram_enable_reg && ram_present;

    // A low bank of zero always reads as one.
    assign low_fixed = (req.write_data[4:0] == 5'd0) ? 5'd1 : req.write_data[4:0];

    // Decode the request and compute the next bank state and its result.
    always_comb
    begin
        ram_enable_next  = ram_enable_reg;
        bank_low_next    = bank_low_reg;
        bank_high_next   = bank_high_reg;
        mode_select_next = mode_select_reg;
        ram_bank_next    = ram_bank_reg;
        use_ram_next     = 1'b0;
        rsp_next         = '0;

        if (req.cmd == cbc_pkg::CMD_READ)
        begin
            unique case (req.address[15:13]) inside
                RGN_ENABLE, RGN_LOW:
                begin
                    rsp_next.outcome     = cbc_pkg::OUTCOME_ROM;
                    rsp_next.rom_address = {7'd0, req.address[13:0]};
                end
                RGN_HIGH, RGN_MODE:
                begin
                    rsp_next.outcome     = cbc_pkg::OUTCOME_ROM;
                    rsp_next.rom_address = {bank_high_reg, bank_low_reg, req.address[13:0]};
                end
                RGN_RAM:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_READ;
                    if (ram_active)
                    begin
                        use_ram_next = 1'b1;
                    end
                    else
                    begin
                        rsp_next.read_data = 8'hFF;
                    end
                end
                default:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_NONE;
                end
            endcase
        end
        else
        begin
            unique case (req.address[15:13])
                RGN_ENABLE:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_WRITE;
                    ram_enable_next  = (req.write_data[3:0] == 4'hA);
                end
                RGN_LOW:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_WRITE;
                    bank_low_next    = low_fixed;
                    if ({1'b0, bank_high_reg, low_fixed} >= rom_bank_count_reg)
                    begin
                        rsp_next.error = cbc_pkg::ERR_ROM_RANGE;
                    end
                end
                RGN_HIGH:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_WRITE;
                    if (mode_select_reg)
                    begin
                        ram_bank_next = req.write_data[1:0];
                    end
                    else
                    begin
                        bank_high_next = req.write_data[1:0];
                        if ({1'b0, req.write_data[1:0], bank_low_reg} >= rom_bank_count_reg)
                        begin
                            rsp_next.error = cbc_pkg::ERR_ROM_RANGE;
                        end
                    end
                    // An out-of-range bank value takes precedence.
                    if (req.write_data[7:2] != 6'd0)
                    begin
                        rsp_next.error = cbc_pkg::ERR_BANK_VALUE;
                    end
                end
                RGN_MODE:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_WRITE;
                    mode_select_next = req.write_data[0];
                    if (!req.write_data[0])
                    begin
                        ram_bank_next = 2'd0;
                    end
                    else
                    begin
                        bank_high_next = 2'd0;
                        if ({3'b000, bank_low_reg} >= rom_bank_count_reg)
                        begin
                            rsp_next.error = cbc_pkg::ERR_ROM_RANGE;
                        end
                    end
                end
                RGN_RAM:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_WRITE;
                end
                default:
                begin
                    rsp_next.outcome = cbc_pkg::OUTCOME_NONE;
                end
            endcase
        end
    end

    // The RAM port serves the clearing sweep first, then request accesses.
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clear_cnt_reg;
            ram_wdata = 8'h00;
        end
        else
        begin
            ram_en    = accept && ram_active && (req.address[15:13] == RGN_RAM);
            ram_we    = (req.cmd == cbc_pkg::CMD_WRITE);
            ram_addr  = ram_index_full[AW-1:0];
            ram_wdata = req.write_data;
        end
    end

    cbc_ram #(
        .Width (8),
        .Depth (RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Control state, configuration and handshake flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= cbc_pkg::ROM_BANK_COUNT_RESET;
            ram_size_code_reg  <= cbc_pkg::RAM_SIZE_CODE_RESET;
            ram_enable_reg     <= 1'b0;
            bank_low_reg       <= 5'd1;
            bank_high_reg      <= 2'd0;
            mode_select_reg    <= 1'b0;
            ram_bank_reg       <= 2'd0;
            clearing_reg       <= 1'b1;
            clear_cnt_reg      <= '0;
            a_valid_reg        <= 1'b0;
            o_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cbc_pkg::CFG_ROM_BANK_COUNT: rom_bank_count_reg <= cfg_data;
                    cbc_pkg::CFG_RAM_SIZE_CODE:  ram_size_code_reg  <= cfg_data[2:0];
                    default:                     rom_bank_count_reg <= rom_bank_count_reg;
                endcase
            end

            if (clearing_reg)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == AW'(RAM_BYTES - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end

            if (accept)
            begin
                ram_enable_reg  <= ram_enable_next;
                bank_low_reg    <= bank_low_next;
                bank_high_reg   <= bank_high_next;
                mode_select_reg <= mode_select_next;
                ram_bank_reg    <= ram_bank_next;
            end

            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                a_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // A RAM read takes its byte from the RAM output as it leaves the middle stage.
    always_comb
    begin
        o_rsp_next = a_rsp_reg;
        if (a_use_ram_reg)
        begin
            o_rsp_next.read_data = ram_rdata;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_rsp_reg     <= rsp_next;
            a_use_ram_reg <= use_ram_next;
        end
        if (advance)
        begin
            o_rsp_reg <= o_rsp_next;
        end
    end

    assign rsp_valid = o_valid_reg;
    assign rsp       = o_rsp_reg;

endmodule

`default_nettype wire
